/* rtl/rtq_pkg.sv */
`timescale 1ns / 1ps
package rtq_pkg;
   localparam int unsigned TimerSlotsDefault = 16;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_CANCEL = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_CANCEL  = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // one command held in the queue between front and back
   typedef struct packed {
      func_type    func;
      logic [63:0] expiry_time;
      logic [31:0] repeat_interval;
      logic [3:0]  cancel_slot;
      logic [31:0] cancel_tag;
      logic [63:0] now_time;
   } cmd_type;

   localparam int unsigned CmdWidth = $bits(cmd_type);
endpackage

/* rtl/rtq_front.sv */
`timescale 1ns / 1ps
module rtq_front
   import rtq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_expiry_time,
   input  logic [31:0] req_repeat_interval,
   input  logic [3:0]  req_cancel_slot,
   input  logic [31:0] req_cancel_tag,
   input  logic [63:0] req_now_time,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);
   // two-entry queue; unknown func is dropped on accept
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       wr_ff, wr_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall && (func_type'(req_func) != FUNC_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_take;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      q_in.func            = func_type'(req_func);
      q_in.expiry_time     = req_expiry_time;
      q_in.repeat_interval = req_repeat_interval;
      q_in.cancel_slot     = req_cancel_slot;
      q_in.cancel_tag      = req_cancel_tag;
      q_in.now_time        = req_now_time;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= q_in;
      end
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end
endmodule

/* rtl/rtq_back.sv */
`timescale 1ns / 1ps
module rtq_back
   import rtq_pkg::*;
#(
   parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot_out,
   output logic [31:0] rsp_tag_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_earliest_changed,
   output logic        rsp_next_valid,
   output logic [63:0] rsp_next_expiry,
   output logic        rsp_last
);
   localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_APPLY = 6'b000100,
      ST_PICK  = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_MIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] exp_ff, exp_in;      // pending expired set of a tick
   logic [63:0] expiry_ff [TIMER_SLOTS];
   logic [31:0] ival_ff   [TIMER_SLOTS];
   logic [31:0] tagm_ff   [TIMER_SLOTS];
   logic [31:0] tag_counter_ff, tag_counter_in;

   cmd_type     cmd_ff, cmd_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] free_ff, free_in;
   logic        free_found_ff, free_found_in;
   logic        any_ff, any_in;
   logic [63:0] best_ff, best_in;
   logic [SW-1:0] bslot_ff, bslot_in;
   logic        ec_ff, ec_in;
   logic [1:0]  st_ff, st_in;

   // per-slot store write
   logic          wr_en;
   logic [SW-1:0] wr_slot;
   logic [63:0]   wr_exp;
   logic          wr_full;
   logic [31:0]   wr_ival, wr_tag;

   // output register
   logic        ov_ff, ov_in;
   logic [1:0]  okind_ff, okind_in;
   logic [3:0]  oslot_ff, oslot_in;
   logic [31:0] otag_ff, otag_in;
   logic [1:0]  ost_ff, ost_in;
   logic        oec_ff, oec_in, onv_ff, onv_in, olast_ff, olast_in;
   logic [63:0] one_ff, one_in;

   logic [SW-1:0] i_s;
   logic          scan_end;
   logic [64:0]   rearm_sum;
   logic          out_free;
   logic          slot_ok;
   logic [SW-1:0] cslot;

   assign i_s       = idx_ff[SW-1:0];
   assign scan_end  = (idx_ff == CW'(TIMER_SLOTS - 1));
   assign out_free  = !ov_ff || !rsp_stall;
   assign rearm_sum = {1'b0, cmd_ff.now_time} + {33'd0, ival_ff[bslot_ff]};
   assign slot_ok   = ({28'd0, cmd_ff.cancel_slot} < 32'(TIMER_SLOTS));
   assign cslot     = SW'(cmd_ff.cancel_slot);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      exp_in = exp_ff;
      tag_counter_in = tag_counter_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      free_in = free_ff;
      free_found_in = free_found_ff;
      any_in = any_ff;
      best_in = best_ff;
      bslot_in = bslot_ff;
      ec_in = ec_ff;
      st_in = st_ff;
      cmd_take = 1'b0;
      wr_en = 1'b0;
      wr_full = 1'b0;
      wr_slot = bslot_ff;
      wr_exp = '0;
      wr_ival = cmd_ff.repeat_interval;
      wr_tag = tag_counter_ff;
      ov_in = ov_ff && rsp_stall;
      okind_in = okind_ff;
      oslot_in = oslot_ff;
      otag_in = otag_ff;
      ost_in = ost_ff;
      oec_in = oec_ff;
      onv_in = onv_ff;
      one_in = one_ff;
      olast_in = olast_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in = cmd;
               idx_in = '0;
               any_in = 1'b0;
               free_found_in = 1'b0;
               free_in = '0;
               exp_in = '0;
               state_in = ST_SCAN;
            end
         end
         // one slot per cycle: min expiry, first free slot, expired set
         ST_SCAN: begin
            if (valid_ff[i_s]) begin
               if (!any_ff || expiry_ff[i_s] < best_ff) begin
                  best_in = expiry_ff[i_s];
               end
               any_in = 1'b1;
               if (expiry_ff[i_s] <= cmd_ff.now_time) begin
                  exp_in[i_s] = 1'b1;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_in = i_s;
            end
            idx_in = idx_ff + 1'b1;
            if (scan_end) begin
               idx_in = '0;
               if (cmd_ff.func == FUNC_TICK) begin
                  any_in = 1'b0;
                  state_in = ST_PICK;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            st_in = STATUS_OK;
            ec_in = 1'b0;
            if (cmd_ff.func == FUNC_ADD) begin
               if (!free_found_ff) begin
                  st_in = STATUS_FULL;
               end else begin
                  ec_in = !any_ff || (cmd_ff.expiry_time < best_ff);
                  tag_counter_in = tag_counter_ff + 32'd1;
                  valid_in[free_ff] = 1'b1;
                  wr_en = 1'b1;
                  wr_full = 1'b1;
                  wr_slot = free_ff;
                  wr_exp = cmd_ff.expiry_time;
                  wr_tag = tag_counter_ff + 32'd1;
               end
            end else begin
               st_in = STATUS_NOT_FOUND;
               if (slot_ok && valid_ff[cslot] && tagm_ff[cslot] == cmd_ff.cancel_tag) begin
                  valid_in[cslot] = 1'b0;
                  st_in = STATUS_OK;
               end
            end
            idx_in = '0;
            any_in = 1'b0;
            state_in = ST_MIN;
         end
         // pick earliest expired slot, lowest slot on ties
         ST_PICK: begin
            if (exp_ff[i_s] && (!any_ff || expiry_ff[i_s] < best_ff)) begin
               best_in = expiry_ff[i_s];
               bslot_in = i_s;
               any_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (scan_end) begin
               idx_in = '0;
               state_in = ST_EMIT;
               if (!(any_ff || exp_ff[i_s])) begin
                  any_in = 1'b0;
                  state_in = ST_MIN;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               okind_in = KIND_EXPIRED;
               oslot_in = 4'(bslot_ff);
               otag_in = tagm_ff[bslot_ff];
               ost_in = STATUS_OK;
               oec_in = 1'b0;
               onv_in = 1'b0;
               one_in = '0;
               olast_in = 1'b0;
               exp_in[bslot_ff] = 1'b0;
               if (ival_ff[bslot_ff] != 32'd0) begin
                  wr_en = 1'b1;
                  wr_exp = rearm_sum[64] ? {64{1'b1}} : rearm_sum[63:0];
               end else begin
                  valid_in[bslot_ff] = 1'b0;
               end
               any_in = 1'b0;
               idx_in = '0;
               state_in = ST_PICK;
            end
         end
         // final min scan, then closing result
         ST_MIN: begin
            if (idx_ff != CW'(TIMER_SLOTS)) begin
               if (valid_ff[i_s] && (!any_ff || expiry_ff[i_s] < best_ff)) begin
                  best_in = expiry_ff[i_s];
                  any_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               ov_in = 1'b1;
               olast_in = 1'b1;
               onv_in = any_ff;
               one_in = any_ff ? best_ff : 64'd0;
               if (cmd_ff.func == FUNC_TICK) begin
                  okind_in = KIND_DONE;
                  oslot_in = '0;
                  otag_in = '0;
                  ost_in = STATUS_OK;
                  oec_in = 1'b0;
               end else if (cmd_ff.func == FUNC_ADD) begin
                  okind_in = KIND_ADD;
                  ost_in = st_ff;
                  oec_in = ec_ff;
                  oslot_in = (st_ff == STATUS_OK) ? 4'(free_ff) : 4'd0;
                  otag_in = (st_ff == STATUS_OK) ? tag_counter_ff : 32'd0;
               end else begin
                  okind_in = KIND_CANCEL;
                  ost_in = st_ff;
                  oec_in = 1'b0;
                  oslot_in = cmd_ff.cancel_slot;
                  otag_in = cmd_ff.cancel_tag;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         expiry_ff[wr_slot] <= wr_exp;
         if (wr_full) begin
            ival_ff[wr_slot] <= wr_ival;
            tagm_ff[wr_slot] <= wr_tag;
         end
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      free_ff <= free_in;
      free_found_ff <= free_found_in;
      any_ff <= any_in;
      best_ff <= best_in;
      bslot_ff <= bslot_in;
      ec_ff <= ec_in;
      st_ff <= st_in;
      exp_ff <= exp_in;
      okind_ff <= okind_in;
      oslot_ff <= oslot_in;
      otag_ff <= otag_in;
      ost_ff <= ost_in;
      oec_ff <= oec_in;
      onv_ff <= onv_in;
      one_ff <= one_in;
      olast_ff <= olast_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         tag_counter_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         tag_counter_ff <= tag_counter_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_slot_out = oslot_ff;
   assign rsp_tag_out = otag_ff;
   assign rsp_status = ost_ff;
   assign rsp_earliest_changed = oec_ff;
   assign rsp_next_valid = onv_ff;
   assign rsp_next_expiry = one_ff;
   assign rsp_last = olast_ff;
endmodule

/* rtl/repeating_timer_queue.sv */
`timescale 1ns / 1ps
// repeating timer queue: a table of TIMER_SLOTS timers behind a two-entry
// command queue. add and cancel run one slot scan to find the earliest
// expiry and a free slot, one update, and one rescan for next expiry. a
// tick runs one scan plus, for each expired timer, a full pick scan of
// the slots and one emit step, then one more pick scan that finds nothing
// and a final scan over the slots; the cost is set by walking the slots
// one per cycle. every item ends with a beat that has last set. func 3 is
// dropped on accept and gives no beat. the front queue keeps accepting
// while the back end works or the output beat is stalled, until both of
// its entries are full.
module repeating_timer_queue
   import rtq_pkg::*;
#(
   parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_expiry_time,
   input  logic [31:0] req_repeat_interval,
   input  logic [3:0]  req_cancel_slot,
   input  logic [31:0] req_cancel_tag,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot_out,
   output logic [31:0] rsp_tag_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_earliest_changed,
   output logic        rsp_next_valid,
   output logic [63:0] rsp_next_expiry,
   output logic        rsp_last
);
   // queued command between front and back
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   rtq_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_expiry_time,
      .req_repeat_interval, .req_cancel_slot, .req_cancel_tag, .req_now_time,
      .cmd_valid, .cmd_take, .cmd
   );

   rtq_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_slot_out, .rsp_tag_out,
      .rsp_status, .rsp_earliest_changed, .rsp_next_valid, .rsp_next_expiry,
      .rsp_last
   );
endmodule

/* rtl/rtq_checker.sv */
`timescale 1ns / 1ps
module rtq_checker
   import rtq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_status,
   input logic        rsp_earliest_changed,
   input logic        rsp_next_valid,
   input logic        rsp_last
);
   // stalled beat holds its kind
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled beat changed");
   // expired beats never close an item, others always do
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_EXPIRED)))
      else $error("last flag wrong");
   // earliest flag only on an ok add
   a_ec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_earliest_changed |->
         rsp_kind == KIND_ADD && rsp_status == STATUS_OK)
      else $error("earliest flag on wrong beat");
   // an ok add leaves a timer pending
   a_nv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ADD && rsp_status == STATUS_OK |->
         rsp_next_valid)
      else $error("add left table empty");
endmodule

bind repeating_timer_queue rtq_checker u_rtq_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_status,
   .rsp_earliest_changed, .rsp_next_valid, .rsp_last
);
